### sv/kthh_pkg.sv
// Package for the k-th largest min-heap block.
// Holds the widths and the structs passed between the level cells and the top level.
// No dependencies.
package kthh_pkg;

	localparam int VAL_W  = 32;
	localparam int PAIR_W = 2 * VAL_W;
	localparam int K_W    = 11;
	// Sized for the largest supported heap of 65536 entries (17 levels).
	localparam int POS_W  = 16;
	localparam int CNT_W  = 17;
	localparam int LVL_W  = 5;

	// Operation token that walks down the chain of level cells.
	typedef struct packed {
		logic                    valid;
		logic                    del;   // 1: sift down from the root, 0: insert
		logic [LVL_W-1:0]        lt;    // level of the new leaf for an insert
		logic [CNT_W-1:0]        n;     // one-based index of the new leaf
		logic [POS_W-1:0]        pos;   // node offset within the current level
		logic signed [VAL_W-1:0] c;     // value being carried
		logic [PAIR_W-1:0]       cur;   // sibling pair holding pos (sift down only)
	} tok_t;

	// Read request from a cell to the cell one level below.
	typedef struct packed {
		logic             rd;
		logic [POS_W-1:0] addr;
	} rdreq_t;

	// Value written into the node that a cell is working on.
	typedef struct packed {
		logic                    en;
		logic signed [VAL_W-1:0] data;
	} node_wr_t;

endpackage

### sv/kthh_in_if.sv
// Input channel of the k-th largest min-heap block.
// Depends on nothing.
interface kthh_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               restart;
	logic               preload;

	modport source (output valid, output value, output restart, output preload, input ready);
	modport sink (input valid, input value, input restart, input preload, output ready);
endinterface

### sv/kthh_out_if.sv
// Result channel of the k-th largest min-heap block.
// Depends on nothing.
interface kthh_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] kth_value;
	logic               heap_full;

	modport source (output valid, output kth_value, output heap_full, input ready);
	modport sink (input valid, input kth_value, input heap_full, output ready);
endinterface

### sv/kth_largest_min_heap_stream.sv
// Top level of the k-th largest min-heap block: controller, root copy and the level chain.
// Depends on kthh_pkg, kthh_in_if, kthh_out_if and kthh_cell.
//
//  channel  | direction | handshake    | payload
//  ---------+-----------+--------------+-------------------------------
//  item     | in        | valid/ready  | value, restart, preload
//  result   | out       | valid/ready  | kth_value, heap_full
//  cfg      | in        | cfg_we       | cfg_wdata (k_count)
//
// One item is handled at a time. Each heap level first reads a pair, then compares and
// writes; a value too small to enter a full heap launches no token and goes straight to done.
// Reset empties the heap and sets k to one; a configuration write also empties it.
// While an untaken result sits in the output register the block holds the next finished
// item and accepts no new one; item.ready is high only when the controller is idle.
module kth_largest_min_heap_stream #(
	parameter int MAX_K = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [kthh_pkg::K_W-1:0]   cfg_wdata,
	kthh_in_if.sink                    item,
	kthh_out_if.source                 result
);
	import kthh_pkg::*;

	localparam int LV = $clog2(MAX_K + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t                  st_q;
	logic [K_W-1:0]          k_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [VAL_W-1:0] root_q;
	logic                    preload_q;
	tok_t                    tok0_q;

	logic [CNT_W-1:0]        eff_k;
	logic [CNT_W-1:0]        cnt0;
	logic [CNT_W-1:0]        n_new;
	logic [LVL_W-1:0]        lt_new;
	logic                    accept;
	logic                    done_any;
	logic                    start_op;
	logic                    emit;

	tok_t                    tok_chain [LV+1];
	rdreq_t                  req_chain [1:LV];
	logic [PAIR_W-1:0]       data_chain [1:LV];
	logic [LV-1:0]           done_v;
	node_wr_t                root_wr;

	assign item.ready = (st_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign done_any   = |done_v;

	// A token is launched for an insert, or for a value that beats the root of a full heap.
	assign start_op = accept && ((cnt0 < eff_k) || (item.value > root_q));
	assign emit     = (st_q == S_DONE) && !preload_q && (!result.valid || result.ready);

	always_comb begin
		if (32'(k_q) > 32'(MAX_K)) begin
			eff_k = CNT_W'(MAX_K);
		end else if (k_q == '0) begin
			eff_k = CNT_W'(1);
		end else begin
			eff_k = CNT_W'(k_q);
		end
	end

	// Level of the new leaf is the position of the top set bit of its one-based index.
	always_comb begin
		cnt0   = item.restart ? '0 : count_q;
		n_new  = cnt0 + CNT_W'(1);
		lt_new = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (n_new[i]) begin
				lt_new = LVL_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			k_q          <= K_W'(1);
			count_q      <= '0;
			tok0_q.valid <= 1'b0;
			result.valid <= 1'b0;
		end else begin
			tok0_q.valid <= start_op;
			result.valid <= emit || (result.valid && !result.ready);
			if (cfg_we) begin
				k_q     <= cfg_wdata;
				count_q <= '0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						preload_q  <= item.preload;
						tok0_q.lt  <= lt_new;
						tok0_q.n   <= n_new;
						tok0_q.pos <= '0;
						tok0_q.c   <= item.value;
						tok0_q.cur <= {{VAL_W{1'b0}}, root_q};
						if (cnt0 < eff_k) begin
							tok0_q.del   <= 1'b0;
							count_q      <= n_new;
							st_q         <= S_RUN;
						end else if (item.value > root_q) begin
							tok0_q.del   <= 1'b1;
							count_q      <= cnt0;
							st_q         <= S_RUN;
						end else begin
							count_q <= cnt0;
							st_q    <= S_DONE;
						end
					end
				end
				S_RUN: begin
					if (done_any) begin
						st_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (preload_q) begin
						st_q <= S_IDLE;
					end else if (!result.valid || result.ready) begin
						result.kth_value <= root_q;
						result.heap_full <= (count_q == eff_k);
						st_q             <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Shadow of the root so that the compare and the result need no RAM read.
	always_ff @(posedge clk) begin
		if (root_wr.en) begin
			root_q <= root_wr.data;
		end
	end

	assign tok_chain[0]   = tok0_q;
	assign data_chain[LV] = '0;

	for (genvar i = 0; i < LV; i++) begin : g_lvl
		if (i == 0) begin : g_root
			kthh_cell #(
				.LEVEL (i),
				.LAST  (i == LV - 1)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tok_in  (tok_chain[i]),
				.tok_out (tok_chain[i+1]),
				.count   (count_q),
				.up_req  ('0),
				.up_data (),
				.dn_req  (req_chain[i+1]),
				.dn_data (data_chain[i+1]),
				.node_wr (root_wr),
				.done    (done_v[i])
			);
		end else begin : g_inner
			kthh_cell #(
				.LEVEL (i),
				.LAST  (i == LV - 1)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tok_in  (tok_chain[i]),
				.tok_out (tok_chain[i+1]),
				.count   (count_q),
				.up_req  (req_chain[i]),
				.up_data (data_chain[i]),
				.dn_req  (req_chain[i+1]),
				.dn_data (data_chain[i+1]),
				.node_wr (),
				.done    (done_v[i])
			);
		end
	end

	// The bottom level never passes a token on nor asks for a level below it.
	a_no_spill: assert property (@(posedge clk) disable iff (!arst_n)
		!tok_chain[LV].valid && !req_chain[LV].rd)
		else $error("token or read request left the bottom level");

	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(done_v))
		else $error("more than one level finished an operation at once");

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_any |-> st_q == S_RUN)
		else $error("operation finished outside the run state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= eff_k)
		else $error("heap holds more than k entries");

	a_start_token: assert property (@(posedge clk) disable iff (!arst_n)
		tok0_q.valid |-> st_q == S_RUN)
		else $error("token issued while the controller is not running");

endmodule

### sv/kthh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kthh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/kthh_cell.sv
// One heap level: a RAM of sibling pairs plus the logic that moves the token one level on.
// Depends on kthh_pkg and kthh_ram.
module kthh_cell #(
	parameter int LEVEL = 0,
	parameter bit LAST  = 1'b0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kthh_pkg::tok_t                     tok_in,
	output kthh_pkg::tok_t                     tok_out,
	input  logic [kthh_pkg::CNT_W-1:0]         count,
	input  kthh_pkg::rdreq_t                   up_req,
	output logic [kthh_pkg::PAIR_W-1:0]        up_data,
	output kthh_pkg::rdreq_t                   dn_req,
	input  logic [kthh_pkg::PAIR_W-1:0]        dn_data,
	output kthh_pkg::node_wr_t                 node_wr,
	output logic                               done
);
	import kthh_pkg::*;

	localparam int AW    = (LEVEL <= 1) ? 1 : LEVEL - 1;
	localparam int DEPTH = (LEVEL <= 1) ? 1 : (1 << (LEVEL - 1));

	tok_t                    tok_q;
	logic                    vld_q;
	logic                    ph_q;
	logic                    rd_own;
	logic                    act;
	logic [PAIR_W-1:0]       ram_rd;
	logic [PAIR_W-1:0]       own_pair;
	logic [PAIR_W-1:0]       wr_pair;
	logic signed [VAL_W-1:0] node;
	logic signed [VAL_W-1:0] left_v;
	logic signed [VAL_W-1:0] right_v;
	logic signed [VAL_W-1:0] pick_v;
	logic signed [VAL_W-1:0] new_node;
	logic signed [VAL_W-1:0] carry;
	logic [CNT_W:0]          left_n;
	logic                    left_ok;
	logic                    right_ok;
	logic                    pick_r;
	logic                    at_tgt;
	logic                    go_on;
	logic [LVL_W-1:0]        shamt;
	logic [CNT_W-1:0]        n_sh;
	logic                    next_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			ph_q  <= 1'b0;
		end else if (tok_in.valid) begin
			vld_q <= 1'b1;
			ph_q  <= 1'b0;
		end else if (vld_q && !ph_q) begin
			ph_q <= 1'b1;
		end else if (vld_q) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			tok_q <= tok_in;
		end
	end

	// The first phase fetches the pair that the decision needs; the second decides and writes.
	assign rd_own = vld_q && !ph_q && !tok_q.del;
	assign act    = vld_q && ph_q;

	always_comb begin
		dn_req      = '0;
		dn_req.rd   = vld_q && !ph_q && tok_q.del && !LAST;
		dn_req.addr = tok_q.pos;
	end

	kthh_ram #(
		.WIDTH (PAIR_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (act),
		.waddr (tok_q.pos[AW:1]),
		.wdata (wr_pair),
		.re    (rd_own || up_req.rd),
		.raddr (up_req.rd ? up_req.addr[AW-1:0] : tok_q.pos[AW:1]),
		.rdata (ram_rd)
	);

	assign up_data = ram_rd;

	always_comb begin
		own_pair = tok_q.del ? tok_q.cur : ram_rd;
		node     = tok_q.pos[0] ? own_pair[PAIR_W-1:VAL_W] : own_pair[VAL_W-1:0];
		left_v   = dn_data[VAL_W-1:0];
		right_v  = dn_data[PAIR_W-1:VAL_W];

		// One-based index of the left child; a child exists when it is within the count.
		left_n   = ((CNT_W + 1)'(1) << (LEVEL + 1)) | ((CNT_W + 1)'(tok_q.pos) << 1);
		left_ok  = left_n <= {1'b0, count};
		right_ok = left_n < {1'b0, count};
		pick_r   = right_ok && (left_v > right_v);
		pick_v   = pick_r ? right_v : left_v;

		at_tgt   = tok_q.lt == LVL_W'(LEVEL);
		shamt    = tok_q.lt - LVL_W'(LEVEL) - LVL_W'(1);
		n_sh     = tok_q.n >> shamt;
		next_bit = n_sh[0];

		if (tok_q.del) begin
			go_on    = !LAST && left_ok && (pick_v < tok_q.c);
			new_node = go_on ? pick_v : tok_q.c;
			carry    = tok_q.c;
		end else begin
			go_on    = !at_tgt;
			new_node = (at_tgt || tok_q.c < node) ? tok_q.c : node;
			carry    = (!at_tgt && tok_q.c < node) ? node : tok_q.c;
		end

		wr_pair = tok_q.pos[0] ? {new_node, own_pair[VAL_W-1:0]}
			: {own_pair[PAIR_W-1:VAL_W], new_node};
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = act && go_on;
		tok_out.pos   = {tok_q.pos[POS_W-2:0], tok_q.del ? pick_r : next_bit};
		tok_out.c     = carry;
		tok_out.cur   = dn_data;
	end

	assign done         = act && !go_on;
	assign node_wr.en   = act;
	assign node_wr.data = new_node;

endmodule
